// ----- sv/ile_pkg.sv -----
// ----------------------------------------------------------------------------
// Indexed list engine package
// Field widths, operation and status codes, and the command that the list
// control broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package ile_pkg;

   localparam int DATA_W   = 32;
   localparam int FUNC_W   = 3;
   localparam int INDEX_W  = 7;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   // Operation codes carried by a request beat.
   localparam logic [FUNC_W-1:0] FUNC_READ = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_HEAD = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_TAIL = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_AT   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_DEL  = 3'd4;

   // Status codes returned with every response beat.
   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // Read data returned when no entry is read.
   localparam logic [DATA_W-1:0] READ_NONE = '1;

   // Movement applied across the whole row of cells.
   typedef enum logic [1:0] {
      SHIFT_HOLD,
      SHIFT_INSERT,
      SHIFT_DELETE
   } shift_type;

   typedef struct packed {
      shift_type          shift;
      logic [DATA_W-1:0]  value;
   } cell_cmd_type;

endpackage

// ----- sv/indexed_list_engine_top.sv -----
// Response: a response beat is registered and appears in the cycle after its request beat is taken.
// Throughput: one request per cycle once busy is low; every operation, shifts
// included, updates all cells together because each storage cell moves its entry in parallel.
// Reset: synchronous; clears the entry count and holds busy high until the
// first cycle after reset. Entries are not cleared and read only once written.
// The receiver cannot stall: each response beat is shown for one cycle only.
// ----------------------------------------------------------------------------
// Indexed list engine
// An ordered list of signed 32-bit values held in a row of DEPTH cells, with
// read, insert at head, tail or position, and delete at position.
// ----------------------------------------------------------------------------
module indexed_list_engine_top
   import ile_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [FUNC_W-1:0]          req_func,
   input  logic [INDEX_W-1:0]         req_index,
   input  logic signed [DATA_W-1:0]   req_value,
   output logic                       rsp_strobe,
   output logic signed [DATA_W-1:0]   rsp_read_value,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [COUNT_W-1:0]         rsp_count
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int CMP_W = (CW > INDEX_W) ? CW : INDEX_W;

   logic                 busy_ff;
   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        count_in;
   logic                 rsp_strobe_ff;
   logic [DATA_W-1:0]    rsp_read_value_ff;
   logic [DATA_W-1:0]    rsp_read_value_in;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [STATUS_W-1:0]  rsp_status_in;
   logic [COUNT_W-1:0]   rsp_count_ff;

   logic                 accept;
   logic [CMP_W-1:0]     idx_ext;
   logic [CMP_W-1:0]     cnt_ext;
   logic                 idx_lt;
   logic                 idx_gt;
   logic                 full;
   logic [AW-1:0]        rd_addr;
   logic [AW-1:0]        pos;
   cell_cmd_type         cmd;
   logic [DATA_W-1:0]    cell_q [DEPTH];

   assign accept = start && !busy_ff;

   // Position compares against the current fill.
   assign idx_ext = CMP_W'(req_index);
   assign cnt_ext = CMP_W'(count_ff);
   assign idx_lt  = (idx_ext < cnt_ext);
   assign idx_gt  = (idx_ext > cnt_ext);
   assign full    = (count_ff == CW'(DEPTH));
   assign rd_addr = AW'(idx_ext);

   // Decode the request beat into a cell command and a response.
   always_comb begin
      rsp_read_value_in = READ_NONE;
      rsp_status_in     = STATUS_DONE;
      count_in          = count_ff;
      pos               = '0;
      cmd.shift         = SHIFT_HOLD;
      cmd.value         = req_value;
      if (accept) begin
         case (req_func)
            FUNC_READ: begin
               if (idx_lt) begin
                  rsp_read_value_in = cell_q[rd_addr];
               end else begin
                  rsp_status_in = STATUS_RANGE;
               end
            end
            FUNC_HEAD: begin
               if (full) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  cmd.shift = SHIFT_INSERT;
                  count_in  = count_ff + 1'b1;
               end
            end
            FUNC_TAIL: begin
               if (full) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  cmd.shift = SHIFT_INSERT;
                  pos       = AW'(count_ff);
                  count_in  = count_ff + 1'b1;
               end
            end
            FUNC_AT: begin
               if (idx_gt) begin
                  rsp_status_in = STATUS_RANGE;
               end else if (full) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  cmd.shift = SHIFT_INSERT;
                  pos       = rd_addr;
                  count_in  = count_ff + 1'b1;
               end
            end
            FUNC_DEL: begin
               if (idx_lt) begin
                  cmd.shift = SHIFT_DELETE;
                  pos       = rd_addr;
                  count_in  = count_ff - 1'b1;
               end else begin
                  rsp_status_in = STATUS_RANGE;
               end
            end
            default: begin
               rsp_status_in = STATUS_DONE;
            end
         endcase
      end
   end

   // Row of storage cells; the head takes the new value from the left.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] left_q;
      logic [DATA_W-1:0] right_q;

      if (i == 0) begin : g_head
         assign left_q = cmd.value;
      end else begin : g_body
         assign left_q = cell_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_q = cell_q[i];
      end else begin : g_inner
         assign right_q = cell_q[i+1];
      end

      ile_cell #(
         .POS_W (AW),
         .IDX   (i)
      ) u_cell (
         .clock   (clock),
         .cmd     (cmd),
         .pos     (pos),
         .left_q  (left_q),
         .right_q (right_q),
         .data_q  (cell_q[i])
      );
   end

   // Control state and the response beat register.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         busy_ff       <= 1'b0;
         count_ff      <= count_in;
         rsp_strobe_ff <= accept;
      end
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_count_ff      <= COUNT_W'(count_in);
   end

   assign busy           = busy_ff;
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;

`ifndef SYNTHESIS
   // Every accepted request beat gives a response beat in the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe_ff)
      else $error("response beat missing after an accepted request");

   // The fill never passes the number of cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count beyond the store depth");

   // A dropped insert is reported only when the store is full.
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && (rsp_status_ff == STATUS_FULL)) |-> (count_ff == CW'(DEPTH)))
      else $error("full status while the store has room");

   // A refused operation never returns read data.
   a_refused_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && (rsp_status_ff != STATUS_DONE)) |-> (rsp_read_value_ff == READ_NONE))
      else $error("read data returned with a refusing status");
`endif

endmodule

// ----- sv/ile_cell.sv -----
// ----------------------------------------------------------------------------
// Indexed list storage cell
// Holds one list entry. On an insert the cells behind the position take the
// entry of their left neighbour and the cell at the position takes the new
// value; on a delete the cells from the position onwards take the entry of
// their right neighbour.
// ----------------------------------------------------------------------------
module ile_cell
   import ile_pkg::*;
#(
   parameter int POS_W = 6,
   parameter int IDX   = 0
) (
   input  logic               clock,
   input  cell_cmd_type       cmd,
   input  logic [POS_W-1:0]   pos,
   input  logic [DATA_W-1:0]  left_q,
   input  logic [DATA_W-1:0]  right_q,
   output logic [DATA_W-1:0]  data_q
);

   localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   logic              at_pos;
   logic              after_pos;

   // Where this cell stands relative to the operation's position.
   assign at_pos    = (pos == MY_POS);
   assign after_pos = (pos < MY_POS);

   // Next entry of this cell.
   always_comb begin
      data_in = data_ff;
      case (cmd.shift)
         SHIFT_INSERT: begin
            if (after_pos) begin
               data_in = left_q;
            end else if (at_pos) begin
               data_in = cmd.value;
            end
         end
         SHIFT_DELETE: begin
            if (at_pos || after_pos) begin
               data_in = right_q;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   // Entry storage; payload only, so no reset.
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_q = data_ff;

endmodule

// ----- sim/indexed_list_engine_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Indexed list engine testbench
// A short table of hand-written beats covers the empty list, the value
// extremes, every operation, out-of-range positions and spare operation codes.
// Random beats follow in phases that grow, shrink or churn the list, which
// fills the store to the brim and drains it again. Each response beat is
// checked against a model of the list that the testbench keeps for itself.
// ----------------------------------------------------------------------------
module indexed_list_engine_top_test;
   import ile_pkg::*;

   localparam int LIST_DEPTH    = 64;
   localparam int CYCLE_LIMIT   = 200_000;
   localparam int PHASE_BEATS   = 100;
   localparam int PHASE_TOTAL   = 17;
   localparam int IDLE_PERCENT  = 22;
   localparam int SETTLE_CYCLES = 4;

   // Operation codes that the block does not define; they must change nothing.
   localparam logic [FUNC_W-1:0] FUNC_SPARE_5 = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

   // Whether a table row carries its own answer or leaves it to the model.
   localparam bit TYPED     = 1'b1;
   localparam bit PREDICTED = 1'b0;

   typedef enum int {
      PHASE_GROW,
      PHASE_SHRINK,
      PHASE_CHURN
   } phase_kind_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic [STATUS_W-1:0]      status;
      logic [COUNT_W-1:0]       count;
   } list_reply_type;

   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic [INDEX_W-1:0]       index;
      logic signed [DATA_W-1:0] value;
      bit                       typed;
      list_reply_type           reply;
   } directed_row_type;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [FUNC_W-1:0]        req_func;
   logic [INDEX_W-1:0]       req_index;
   logic signed [DATA_W-1:0] req_value;
   logic                     rsp_strobe;
   logic signed [DATA_W-1:0] rsp_read_value;
   logic [STATUS_W-1:0]      rsp_status;
   logic [COUNT_W-1:0]       rsp_count;

   // Model of the list contents and length.
   logic signed [DATA_W-1:0] list_store [LIST_DEPTH];
   int                       list_len;

   list_reply_type   pending_replies [$];
   directed_row_type directed_rows [$];
   int               mismatch_count;
   int               cycle_count;
   bit               quiet;

   indexed_list_engine_top #(
      .DEPTH (LIST_DEPTH)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_index      (req_index),
      .req_value      (req_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Guard against a hung block.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      $display("%0t: %s: got %h, expected %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Open a slot at pos and place the value there; later entries move back.
   function automatic void insert_entry(input int pos, input logic signed [DATA_W-1:0] value);
      for (int i = list_len; i > pos; i--)
         list_store[i] = list_store[i-1];
      list_store[pos] = value;
      list_len++;
   endfunction

   // Apply one operation to the model and return the response it gives.
   function automatic list_reply_type predict_list_op(input logic [FUNC_W-1:0] func,
                                                      input logic [INDEX_W-1:0] index,
                                                      input logic signed [DATA_W-1:0] value);
      list_reply_type reply;
      int             pos;
      reply.read_value = READ_NONE;
      reply.status     = STATUS_DONE;
      pos              = int'(index);
      case (func)
         FUNC_READ: begin
            if (pos < list_len)
               reply.read_value = list_store[pos];
            else
               reply.status = STATUS_RANGE;
         end
         FUNC_HEAD: begin
            if (list_len >= LIST_DEPTH)
               reply.status = STATUS_FULL;
            else
               insert_entry(0, value);
         end
         FUNC_TAIL: begin
            if (list_len >= LIST_DEPTH)
               reply.status = STATUS_FULL;
            else
               insert_entry(list_len, value);
         end
         FUNC_AT: begin
            // The position check takes precedence over the full check.
            if (pos > list_len)
               reply.status = STATUS_RANGE;
            else if (list_len >= LIST_DEPTH)
               reply.status = STATUS_FULL;
            else
               insert_entry(pos, value);
         end
         FUNC_DEL: begin
            if (pos < list_len) begin
               for (int i = pos; i + 1 < list_len; i++)
                  list_store[i] = list_store[i+1];
               list_len--;
            end else begin
               reply.status = STATUS_RANGE;
            end
         end
         default: ;
      endcase
      reply.count = COUNT_W'(list_len);
      return reply;
   endfunction

   function automatic void add_row(input logic [FUNC_W-1:0] func,
                                   input logic [INDEX_W-1:0] index,
                                   input logic signed [DATA_W-1:0] value,
                                   input bit typed,
                                   input logic signed [DATA_W-1:0] read_value,
                                   input logic [STATUS_W-1:0] status,
                                   input logic [COUNT_W-1:0] count);
      directed_row_type row;
      row.func             = func;
      row.index            = index;
      row.value            = value;
      row.typed            = typed;
      row.reply.read_value = read_value;
      row.reply.status     = status;
      row.reply.count      = count;
      directed_rows.push_back(row);
   endfunction

   // Present one request beat, wait until it is taken, then record the answer.
   // Called at a rising edge; start is assigned at most once per edge.
   task automatic send_beat(input logic [FUNC_W-1:0] func, input logic [INDEX_W-1:0] index,
                            input logic signed [DATA_W-1:0] value, input bit typed,
                            input list_reply_type typed_reply);
      int             gap;
      list_reply_type predicted;
      if (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
         start <= 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(posedge clock);
      end
      start     <= 1'b1;
      req_func  <= func;
      req_index <= index;
      req_value <= value;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = predict_list_op(func, index, value);
      pending_replies.push_back(typed ? typed_reply : predicted);
   endtask

   // Hold the request side off until every outstanding response has arrived.
   task automatic drain_replies();
      start <= 1'b0;
      do @(posedge clock); while (pending_replies.size() != 0);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      if ($urandom_range(0, 7) != 0)
         return $urandom();
      case ($urandom_range(0, 3))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         default: return '1;
      endcase
   endfunction

   // Build one random beat, leaning towards the operations that the phase favours.
   task automatic send_random_beat(input phase_kind_type kind);
      logic [FUNC_W-1:0]  func;
      logic [INDEX_W-1:0] index;
      int                 roll;
      int                 insert_pct;
      int                 delete_pct;
      list_reply_type     unused;
      unused     = '0;
      insert_pct = (kind == PHASE_GROW) ? 70 : (kind == PHASE_SHRINK) ? 10 : 40;
      delete_pct = (kind == PHASE_GROW) ? 10 : (kind == PHASE_SHRINK) ? 70 : 35;
      index      = INDEX_W'($urandom_range(0, 127));
      roll       = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) begin
         // Noise: any code, any position.
         func = FUNC_W'($urandom_range(0, 7));
      end else if (roll < insert_pct) begin
         case ($urandom_range(0, 2))
            0:       func = FUNC_HEAD;
            1:       func = FUNC_TAIL;
            default: func = FUNC_AT;
         endcase
         if (func == FUNC_AT && $urandom_range(0, 9) != 0)
            index = INDEX_W'($urandom_range(0, list_len));
      end else begin
         func = (roll < insert_pct + delete_pct) ? FUNC_DEL : FUNC_READ;
         if (list_len > 0 && $urandom_range(0, 9) != 0)
            index = INDEX_W'($urandom_range(0, list_len - 1));
      end
      send_beat(func, index, pick_value(), PREDICTED, unused);
   endtask

   // Response checker: every strobe must match the oldest outstanding answer.
   always @(posedge clock) begin : check_replies
      list_reply_type want;
      if (reset === 1'b0) begin
         if (rsp_strobe === 1'b1) begin
            if (pending_replies.size() == 0) begin
               report_mismatch("response beat with nothing outstanding", rsp_read_value, '0);
            end else begin
               want = pending_replies.pop_front();
               if (rsp_read_value !== want.read_value)
                  report_mismatch("read_value", rsp_read_value, want.read_value);
               if (rsp_status !== want.status)
                  report_mismatch("status", DATA_W'(rsp_status), DATA_W'(want.status));
               if (rsp_count !== want.count)
                  report_mismatch("count", DATA_W'(rsp_count), DATA_W'(want.count));
            end
         end else if (rsp_strobe !== 1'b0) begin
            report_mismatch("strobe unknown", DATA_W'(rsp_strobe), '0);
         end
      end
   end

   initial begin
      phase_kind_type kind;
      reset          <= 1'b1;
      start          <= 1'b0;
      req_func       <= FUNC_READ;
      req_index      <= '0;
      req_value      <= '0;
      quiet          = 1'b0;
      mismatch_count = 0;
      list_len       = 0;

      // Empty list: nothing to read or delete, and no position past the head.
      add_row(FUNC_READ,    7'd0,   32'sd0,           TYPED, READ_NONE, STATUS_RANGE, 7'd0);
      add_row(FUNC_DEL,     7'd0,   32'sd0,           TYPED, READ_NONE, STATUS_RANGE, 7'd0);
      add_row(FUNC_AT,      7'd1,   32'sd9,           TYPED, READ_NONE, STATUS_RANGE, 7'd0);
      add_row(FUNC_SPARE_5, 7'd0,   32'sd0,           TYPED, READ_NONE, STATUS_DONE,  7'd0);
      // Fill with the extremes: head, tail, middle and a position equal to the count.
      add_row(FUNC_HEAD,    7'd0,   32'sh7FFF_FFFF,   TYPED, READ_NONE, STATUS_DONE,  7'd1);
      add_row(FUNC_TAIL,    7'd127, 32'sh8000_0000,   TYPED, READ_NONE, STATUS_DONE,  7'd2);
      add_row(FUNC_AT,      7'd1,   32'sd0,           TYPED, READ_NONE, STATUS_DONE,  7'd3);
      add_row(FUNC_AT,      7'd3,   -32'sd1,          TYPED, READ_NONE, STATUS_DONE,  7'd4);
      add_row(FUNC_READ,    7'd0,   32'sd5,           TYPED, 32'sh7FFF_FFFF, STATUS_DONE, 7'd4);
      add_row(FUNC_READ,    7'd1,   32'sd0,           TYPED, 32'sd0,         STATUS_DONE, 7'd4);
      add_row(FUNC_READ,    7'd2,   32'sd0,           TYPED, 32'sh8000_0000, STATUS_DONE, 7'd4);
      add_row(FUNC_READ,    7'd3,   32'sd0,           TYPED, -32'sd1,        STATUS_DONE, 7'd4);
      // Positions past the end are ignored.
      add_row(FUNC_READ,    7'd4,   32'sd0,           TYPED, READ_NONE, STATUS_RANGE, 7'd4);
      add_row(FUNC_READ,    7'd127, 32'sd0,           TYPED, READ_NONE, STATUS_RANGE, 7'd4);
      add_row(FUNC_DEL,     7'd127, 32'sd0,           TYPED, READ_NONE, STATUS_RANGE, 7'd4);
      add_row(FUNC_AT,      7'd127, 32'sd5,           TYPED, READ_NONE, STATUS_RANGE, 7'd4);
      add_row(FUNC_SPARE_6, 7'd127, -32'sd1,          TYPED, READ_NONE, STATUS_DONE,  7'd4);
      add_row(FUNC_SPARE_7, 7'd64,  32'sh7FFF_FFFF,   TYPED, READ_NONE, STATUS_DONE,  7'd4);
      // Deletes close the gap.
      add_row(FUNC_DEL,     7'd1,   32'sd0,           TYPED, READ_NONE, STATUS_DONE,  7'd3);
      add_row(FUNC_READ,    7'd1,   32'sd0,           TYPED, 32'sh8000_0000, STATUS_DONE, 7'd3);
      add_row(FUNC_DEL,     7'd0,   32'sd0,           TYPED, READ_NONE, STATUS_DONE,  7'd2);
      add_row(FUNC_READ,    7'd0,   32'sd0,           TYPED, 32'sh8000_0000, STATUS_DONE, 7'd2);
      add_row(FUNC_HEAD,    7'd0,   32'sh1234_5678,   PREDICTED, '0, '0, '0);
      add_row(FUNC_AT,      7'd2,   32'sh5555_AAAA,   PREDICTED, '0, '0, '0);
      add_row(FUNC_READ,    7'd2,   32'sd0,           PREDICTED, '0, '0, '0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_beat(directed_rows[i].func, directed_rows[i].index, directed_rows[i].value,
                   directed_rows[i].typed, directed_rows[i].reply);
      drain_replies();

      // Random phases: the first fills the store, the second empties it.
      for (int phase = 0; phase < PHASE_TOTAL; phase++) begin
         if (phase == 0)
            kind = PHASE_GROW;
         else if (phase == 1)
            kind = PHASE_SHRINK;
         else
            kind = phase_kind_type'($urandom_range(0, 2));
         quiet = (phase == 6 || phase == 7);
         for (int beat = 0; beat < PHASE_BEATS; beat++)
            send_random_beat(kind);
         if ($urandom_range(0, 1) == 0)
            drain_replies();
      end
      start <= 1'b0;

      while (pending_replies.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
